@@ design/msf_ttf_pkg.sv @@
// Shared types and constants for the MSF timecode text-to-frames block.
// Used by the character parser and the top level; no dependencies.
package msf_ttf_pkg;

  localparam logic [1:0] PHASE_SKIP  = 2'd0;
  localparam logic [1:0] PHASE_GROUP = 2'd1;
  localparam logic [1:0] PHASE_DONE  = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [6:0] MAX_SECONDS = 7'd59;
  localparam logic [6:0] MAX_FRAMES  = 7'd74;

  typedef struct packed {
    logic       valid;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic [6:0] frames;
  } msf_grp_t;

endpackage

@@ design/msf_ttf_parser.sv @@
// Character parser: skips leading whitespace, collects up to three digit groups.
// Emits the group values on the last character of a string. Uses msf_ttf_pkg.
module msf_ttf_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            char_byte,
  input  logic                  last,
  output msf_ttf_pkg::msf_grp_t grp
);
  import msf_ttf_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] gidx_r, gidx_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;
  logic [6:0] gval_r [3];
  logic [6:0] gval_nxt [3];

  logic       is_space;
  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] acc;
  logic [1:0] count;

  assign is_space = (char_byte == CHAR_SPACE) ||
                    (char_byte >= CHAR_TAB && char_byte <= CHAR_CR);
  assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
  assign digit    = 4'(char_byte - CHAR_ZERO);

  always_comb begin
    logic [1:0] ph;
    ph        = phase_r;
    gidx_nxt  = gidx_r;
    dcnt_nxt  = dcnt_r;
    gval_nxt  = gval_r;
    acc       = {1'b0, gval_r[gidx_r]};
    acc       = (acc << 3) + (acc << 1) + {4'd0, digit};
    if (ph == PHASE_SKIP && !is_space) begin
      ph = PHASE_GROUP;
    end
    if (ph == PHASE_GROUP) begin
      if (dcnt_r != 2'd2 && is_digit) begin
        gval_nxt[gidx_r] = acc[6:0];
        dcnt_nxt         = dcnt_r + 2'd1;
      end else if (char_byte == CHAR_COLON && dcnt_r != 2'd0) begin
        if (gidx_r == 2'd2) begin
          ph = PHASE_DONE;
        end else begin
          gidx_nxt = gidx_r + 2'd1;
          dcnt_nxt = 2'd0;
        end
      end else begin
        ph = PHASE_DONE;
      end
    end
    phase_nxt = ph;
  end

  assign count = gidx_nxt + {1'b0, (dcnt_nxt != 2'd0)};

  always_comb begin
    grp.valid   = take && last;
    grp.minutes = '0;
    grp.seconds = '0;
    grp.frames  = '0;
    case (count)
      2'd1: begin
        grp.frames = gval_nxt[0];
      end
      2'd2: begin
        grp.seconds = gval_nxt[0];
        grp.frames  = gval_nxt[1];
      end
      2'd3: begin
        grp.minutes = gval_nxt[0];
        grp.seconds = gval_nxt[1];
        grp.frames  = gval_nxt[2];
      end
      default: begin
        grp.frames = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      phase_r   <= PHASE_SKIP;
      gidx_r    <= '0;
      dcnt_r    <= '0;
      gval_r[0] <= '0;
      gval_r[1] <= '0;
      gval_r[2] <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      gidx_r  <= gidx_nxt;
      dcnt_r  <= dcnt_nxt;
      gval_r  <= gval_nxt;
    end
  end

endmodule

@@ design/msf_timecode_text_to_frames.sv @@
// Top level: CD timecode text to frame count at 75 frames per second.
// After its last character is accepted, a result passes through p1_r, the p2 registers and the output registers.
// Throughput: one character per cycle; the whole pipeline holds while out_valid and out_stall are both high.
// Reset (rst_n low, synchronous) clears the parser and all pipeline valids.
// Depends on msf_ttf_pkg and msf_ttf_parser.
module msf_timecode_text_to_frames (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [18:0] out_frame_count,
  output logic        out_out_of_range
);
  import msf_ttf_pkg::*;

  logic      advance;
  logic      take;
  msf_grp_t  grp;
  msf_grp_t  p1_r;

  logic        p2_valid_r;
  logic [12:0] p2_secs_r;
  logic [6:0]  p2_frames_r;
  logic        p2_err_r;

  logic [12:0] mins13;
  logic [12:0] secs_nxt;
  logic [18:0] secs19;
  logic [18:0] count_nxt;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign take     = in_valid && advance;

  msf_ttf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_byte (in_char_byte),
    .last      (in_last),
    .grp       (grp)
  );

  assign mins13    = {6'd0, p1_r.minutes};
  assign secs_nxt  = (mins13 << 6) - (mins13 << 2) + {6'd0, p1_r.seconds};
  assign secs19    = {6'd0, p2_secs_r};
  assign count_nxt = (secs19 << 6) + (secs19 << 3) + (secs19 << 1) + secs19
                     + {12'd0, p2_frames_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid <= 1'b0;
      p2_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else if (advance) begin
      p1_r.valid       <= grp.valid;
      p2_valid_r       <= p1_r.valid;
      out_valid        <= p2_valid_r;
      p1_r.minutes     <= grp.minutes;
      p1_r.seconds     <= grp.seconds;
      p1_r.frames      <= grp.frames;
      p2_secs_r        <= secs_nxt;
      p2_frames_r      <= p1_r.frames;
      p2_err_r         <= (p1_r.seconds > MAX_SECONDS) || (p1_r.frames > MAX_FRAMES);
      out_frame_count  <= p2_err_r ? '0 : count_nxt;
      out_out_of_range <= p2_err_r;
    end
  end

endmodule

@@ verif/msf_ttf_checker.sv @@
// Checker for msf_timecode_text_to_frames: watches the character and result channels,
// parses each accepted timecode string on its own and compares every frame count.
// Depends on msf_ttf_pkg; instantiated by msf_timecode_text_to_frames_tb.
module msf_ttf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [18:0] out_frame_count,
  input  logic        out_out_of_range,
  output int          error_count,
  output int          frames_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import msf_ttf_pkg::*;

  localparam int unsigned FRAMES_PER_SECOND  = 75;
  localparam int unsigned SECONDS_PER_MINUTE = 60;

  typedef struct packed {
    logic [18:0] frame_count;
    logic        out_of_range;
  } frame_result_t;

  frame_result_t expected_frames[$];

  logic [1:0] phase;
  logic [1:0] grp_idx;
  logic [1:0] digits;
  logic [6:0] grp_val[3];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic clear_parser();
    phase = PHASE_SKIP;
    grp_idx = 2'd0;
    digits = 2'd0;
    foreach (grp_val[i]) grp_val[i] = 7'd0;
  endtask

  function automatic logic is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  task automatic absorb_char(input logic [7:0] c);
    if (phase == PHASE_SKIP) begin
      if (is_blank(c)) return;
      phase = PHASE_GROUP;
    end
    if (phase != PHASE_GROUP) return;
    if (digits < 2'd2 && c >= CHAR_ZERO && c <= CHAR_NINE) begin
      grp_val[grp_idx] = 7'(grp_val[grp_idx] * 10 + (c - CHAR_ZERO));
      digits++;
      return;
    end
    if (c == CHAR_COLON && digits != 2'd0) begin
      if (grp_idx == 2'd2) begin
        phase = PHASE_DONE;
      end else begin
        grp_idx++;
        digits = 2'd0;
      end
      return;
    end
    phase = PHASE_DONE;
  endtask

  function automatic frame_result_t frames_of_string();
    int unsigned   n_groups;
    int unsigned   mins;
    int unsigned   secs;
    int unsigned   frms;
    frame_result_t r;
    mins = 0;
    secs = 0;
    frms = 0;
    n_groups = grp_idx + (digits != 2'd0 ? 1 : 0);
    case (n_groups)
      1: begin
        frms = grp_val[0];
      end
      2: begin
        secs = grp_val[0];
        frms = grp_val[1];
      end
      3: begin
        mins = grp_val[0];
        secs = grp_val[1];
        frms = grp_val[2];
      end
      default: ;
    endcase
    if (secs > MAX_SECONDS || frms > MAX_FRAMES) begin
      r.frame_count = 19'd0;
      r.out_of_range = 1'b1;
    end else begin
      r.frame_count = 19'((mins * SECONDS_PER_MINUTE + secs) * FRAMES_PER_SECOND + frms);
      r.out_of_range = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      clear_parser();
      expected_frames.delete();
    end else begin
      if (in_valid && !in_stall) begin
        absorb_char(in_char_byte);
        if (in_last) begin
          expected_frames.push_back(frames_of_string());
          clear_parser();
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("unexpected item frame_count=%0d out_of_range=%0b",
                                    out_frame_count, out_out_of_range));
        end else begin
          want = expected_frames.pop_front();
          if (out_frame_count !== want.frame_count)
            report_mismatch($sformatf("frame_count %0d, expected %0d",
                                      out_frame_count, want.frame_count));
          if (out_out_of_range !== want.out_of_range)
            report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                      out_out_of_range, want.out_of_range));
        end
      end
    end
    frames_pending = expected_frames.size();
  end

endmodule

@@ verif/msf_timecode_text_to_frames_tb.sv @@
// Testbench top for msf_timecode_text_to_frames: drives timecode strings one character
// per item with random gaps and output stalls; msf_ttf_checker predicts and compares.
// Depends on msf_ttf_pkg, msf_ttf_checker and the block itself.
module msf_timecode_text_to_frames_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msf_ttf_pkg::*;

  localparam int RANDOM_CHARS = 330;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_char_byte = 8'd0;
  logic        in_last = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [18:0] out_frame_count;
  logic        out_out_of_range;

  int mismatches;
  int frames_pending;
  int cycles = 0;
  int chars_sent = 0;
  bit calm = 1'b0;

  msf_timecode_text_to_frames dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_count  (out_frame_count),
    .out_out_of_range (out_out_of_range)
  );

  msf_ttf_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_count  (out_frame_count),
    .out_out_of_range (out_out_of_range),
    .error_count      (mismatches),
    .frames_pending   (frames_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    in_last <= is_last;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] s[$]);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q);
  endtask

  task automatic send_random_timecode();
    logic [7:0] q[$];
    int n_groups;
    int w;
    int v;
    repeat ($urandom_range(0, 2)) begin
      w = $urandom_range(CHAR_TAB, CHAR_CR + 1);
      q.push_back(w > CHAR_CR ? CHAR_SPACE : 8'(w));
    end
    n_groups = $urandom_range(1, 3);
    for (int g = 0; g < n_groups; g++) begin
      if (g > 0) q.push_back(CHAR_COLON);
      v = $urandom_range(0, ($urandom_range(0, 3) != 0) ? 59 : 99);
      if ($urandom_range(0, 2) != 0) q.push_back(8'(CHAR_ZERO + v / 10));
      q.push_back(8'(CHAR_ZERO + v % 10));
    end
    case ($urandom_range(0, 5))
      0: q.push_back(CHAR_COLON);
      1: q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      2: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    send_bytes(q);
  endtask

  task automatic send_noise();
    logic [7:0] q[$];
    logic [7:0] pick[$];
    pick = {CHAR_ZERO, CHAR_NINE, CHAR_COLON, CHAR_SPACE, 8'h35};
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1)) q.push_back(8'($urandom_range(0, 255)));
      else q.push_back(pick[$urandom_range(0, pick.size() - 1)]);
    end
    send_bytes(q);
  endtask

  initial begin
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    string directed[];
    int start;
    directed = '{"0", "9", "74", "75", "99", "59:74", "60:00", "99:59:74",
                 "00:00:00", "123", "12::34", ":12", "5:", "1:2:3:4", "/;"};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_text(directed[i]);
    send_bytes({CHAR_SPACE, CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR, 8'h31, 8'h32});
    send_bytes({8'h08, 8'h37});
    send_bytes({8'h0E, 8'h37});
    send_bytes({8'hFF, 8'h33});
    send_bytes({8'h80});
    send_bytes({CHAR_SPACE});
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) != 0) send_random_timecode();
      else send_noise();
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (frames_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/msf_ttf_pkg.sv
design/msf_ttf_parser.sv
design/msf_timecode_text_to_frames.sv
verif/msf_ttf_checker.sv
verif/msf_timecode_text_to_frames_tb.sv
